// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file heb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define HEB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also covers reset cycles.
`define HEB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/heb_pkg.sv =====
// Package: shared constants, types and state encodings of the edge bucket router.
`timescale 1ns / 1ps

package heb_pkg;

  localparam int MAX_PARTS   = 64;
  localparam int COUNT_WIDTH = 32;

  localparam int NodeW    = 31;
  localparam int PartW    = 7;
  localparam int IvalW    = 31;
  localparam int BucketW  = 7;
  localparam int SlotW    = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  localparam int HashW     = 64;
  localparam int HalfW     = HashW / 2;
  localparam int HashStepW = $clog2(HashW);

  localparam int NumBuckets = MAX_PARTS + 1;
  localparam int IdxW       = $clog2(NumBuckets);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [HashW-1:0] FMIX_MUL1  = 64'hff51afd7ed558ccd;
  localparam logic [HashW-1:0] FMIX_MUL2  = 64'hc4ceb9fe1a85ec53;
  localparam int               FMIX_SHIFT = 33;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [SlotW-1:0]       SLOT_MAX  = SlotW'(COUNT_MAX);

  typedef enum logic [CfgIdxW-1:0] {
    REG_PART_COUNT     = CfgIdxW'(0),
    REG_INFER_INTERVAL = CfgIdxW'(1)
  } heb_reg_t;

  // Effective configuration seen by the front end.
  typedef struct packed {
    logic [PartW-1:0] parts;
    logic [IvalW-1:0] ival;
  } heb_cfg_t;

  // Classified edge handed from front end to back end.
  typedef struct packed {
    logic [IdxW-1:0] bucket;
    logic            infer;
    logic            new_batch;
  } heb_task_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_DIV,
    F_PUSH
  } heb_front_state_t;

  typedef enum logic {
    B_IDLE,
    B_UPDATE
  } heb_back_state_t;

endpackage

// ===== rtl/core/heb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module heb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/heb_fmix.sv =====
// 64-bit murmur finalizer, four-stage pipeline built from 32x32 partial products.
`timescale 1ns / 1ps

module heb_fmix import heb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NodeW-1:0] key,
  output logic             done,
  output logic [HashW-1:0] hash
);

  function automatic logic [HashW-1:0] xorshift(input logic [HashW-1:0] v);
    return v ^ (v >> FMIX_SHIFT);
  endfunction

  logic [HashW-1:0] x0, x1;
  logic [HashW-1:0] p_ll_r, y1_r, q_ll_r, y2_r;
  logic [HalfW-1:0] p_hl_r, p_lh_r, q_hl_r, q_lh_r;
  logic [3:0]       vld_r;

  assign x0 = xorshift({{(HashW-NodeW){1'b0}}, key});
  assign x1 = xorshift(y1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  // low 64 bits of x * C = lo*lo + ((hi*lo + lo*hi) << 32)
  always_ff @(posedge clk) begin
    p_ll_r <= x0[HalfW-1:0] * FMIX_MUL1[HalfW-1:0];
    p_hl_r <= x0[HashW-1:HalfW] * FMIX_MUL1[HalfW-1:0];
    p_lh_r <= x0[HalfW-1:0] * FMIX_MUL1[HashW-1:HalfW];
    y1_r   <= p_ll_r + {p_hl_r + p_lh_r, {HalfW{1'b0}}};
    q_ll_r <= x1[HalfW-1:0] * FMIX_MUL2[HalfW-1:0];
    q_hl_r <= x1[HashW-1:HalfW] * FMIX_MUL2[HalfW-1:0];
    q_lh_r <= x1[HalfW-1:0] * FMIX_MUL2[HashW-1:HalfW];
    y2_r   <= q_ll_r + {q_hl_r + q_lh_r, {HalfW{1'b0}}};
  end

  assign done = vld_r[3];
  assign hash = xorshift(y2_r);

endmodule

// ===== rtl/core/heb_rem.sv =====
// Bit-serial remainder unit: three restoring remainder lanes, one dividend bit per cycle.
`timescale 1ns / 1ps

module heb_rem import heb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [HashW-1:0] hash_s,
  input  logic [HashW-1:0] hash_d,
  input  logic [IvalW-1:0] ival,
  input  logic [PartW-1:0] parts,
  output logic             done,
  output logic             rem_s_zero,
  output logic             rem_d_zero,
  output logic [PartW-1:0] rem_part
);

  logic                 busy_r, done_r;
  logic [HashStepW-1:0] cnt_r;
  logic [HashW-1:0]     ds_r, dd_r;
  logic [IvalW-1:0]     rs_r, rd_r, rs_nxt, rd_nxt;
  logic [PartW-1:0]     rp_r, rp_nxt;
  logic [IvalW:0]       ts, td;
  logic [PartW:0]       tp;

  // shift in next bit, subtract divisor once if it fits
  always_comb begin
    ts = {rs_r, ds_r[HashW-1]};
    td = {rd_r, dd_r[HashW-1]};
    tp = {rp_r, dd_r[HashW-1]};
    rs_nxt = (ts >= {1'b0, ival})  ? IvalW'(ts - {1'b0, ival})  : IvalW'(ts);
    rd_nxt = (td >= {1'b0, ival})  ? IvalW'(td - {1'b0, ival})  : IvalW'(td);
    rp_nxt = (tp >= {1'b0, parts}) ? PartW'(tp - {1'b0, parts}) : PartW'(tp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == HashStepW'(HashW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ds_r <= hash_s;
      dd_r <= hash_d;
      rs_r <= '0;
      rd_r <= '0;
      rp_r <= '0;
    end else if (busy_r) begin
      ds_r <= ds_r << 1;
      dd_r <= dd_r << 1;
      rs_r <= rs_nxt;
      rd_r <= rd_nxt;
      rp_r <= rp_nxt;
    end
  end

  assign done       = done_r;
  assign rem_s_zero = (rs_r == '0);
  assign rem_d_zero = (rd_r == '0);
  assign rem_part   = rp_r;

endmodule

// ===== rtl/core/heb_front.sv =====
// Front end: accepts edges, hashes both ids and classifies the target bucket.
`timescale 1ns / 1ps

module heb_front import heb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NodeW-1:0] in_source_node,
  input  logic [NodeW-1:0] in_dest_node,
  input  logic             in_new_batch,
  input  heb_cfg_t         cfg,
  output logic             q_push,
  output heb_task_t        q_data,
  input  logic             q_ready
);

  heb_front_state_t state_r, state_nxt;
  logic             nb_r;
  logic             accept;
  logic             done_s, done_d, hash_done;
  logic [HashW-1:0] hash_s, hash_d;
  logic             rem_start, rem_done;
  logic             rem_s_zero, rem_d_zero;
  logic [PartW-1:0] rem_part;
  logic             infer;

  assign accept = in_valid && in_ready;

  heb_fmix u_fmix_src (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_source_node),
    .done  (done_s),
    .hash  (hash_s)
  );

  heb_fmix u_fmix_dst (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_dest_node),
    .done  (done_d),
    .hash  (hash_d)
  );

  assign hash_done = done_s && done_d;

  heb_rem u_rem (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (rem_start),
    .hash_s     (hash_s),
    .hash_d     (hash_d),
    .ival       (cfg.ival),
    .parts      (cfg.parts),
    .done       (rem_done),
    .rem_s_zero (rem_s_zero),
    .rem_d_zero (rem_d_zero),
    .rem_part   (rem_part)
  );

  assign infer            = rem_s_zero || rem_d_zero;
  assign q_data.infer     = infer;
  assign q_data.bucket    = infer ? IdxW'(cfg.parts) : IdxW'(rem_part);
  assign q_data.new_batch = nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nb_r <= in_new_batch;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rem_start = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = F_HASH;
        end
      end
      F_HASH: begin
        if (hash_done) begin
          rem_start = 1'b1;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (rem_done) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_push = q_ready;
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/heb_queue.sv =====
// Small FIFO between front end and back end.
`timescale 1ns / 1ps

module heb_queue import heb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  heb_task_t push_data,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output heb_task_t pop_data
);

  heb_task_t        mem_r [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != QCntW'(QueueDepth));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/heb_back.sv =====
// Back end: per-bucket counter update and result register.
`timescale 1ns / 1ps

module heb_back import heb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  heb_task_t          q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BucketW-1:0] out_bucket,
  output logic [SlotW-1:0]   out_slot,
  output logic               out_infer_edge,
  output logic               out_slot_overflow
);

  heb_back_state_t         state_r, state_nxt;
  heb_task_t               task_r;
  logic [NumBuckets-1:0]   valid_r;
  logic [COUNT_WIDTH-1:0]  rdata, count;
  logic                    sat, upd_we, load_out;
  logic                    out_valid_r, out_infer_r, out_ovf_r;
  logic [BucketW-1:0]      out_bucket_r;
  logic [SlotW-1:0]        out_slot_r;

  heb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NumBuckets)
  ) u_counters (
    .clk   (clk),
    .we    (upd_we),
    .waddr (task_r.bucket),
    .wdata (count + 1'b1),
    .raddr (q_data.bucket),
    .rdata (rdata)
  );

  // entry without valid bit reads as zero
  assign count = valid_r[task_r.bucket] ? rdata : '0;
  assign sat   = (count == COUNT_MAX);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    upd_we    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          state_nxt = B_UPDATE;
        end
      end
      B_UPDATE: begin
        upd_we    = !sat;
        load_out  = 1'b1;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_data.new_batch) begin
        valid_r <= '0;
      end else if (upd_we) begin
        valid_r[task_r.bucket] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      task_r <= q_data;
    end
    if (load_out) begin
      out_bucket_r <= BucketW'(task_r.bucket);
      out_slot_r   <= SlotW'(count);
      out_infer_r  <= task_r.infer;
      out_ovf_r    <= sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bucket        = out_bucket_r;
  assign out_slot          = out_slot_r;
  assign out_infer_edge    = out_infer_r;
  assign out_slot_overflow = out_ovf_r;

endmodule

// ===== rtl/core/hash_edge_bucket_router.sv =====
// An accepted edge passes the 4 hash stages and the 64 remainder steps on its way to out_valid.
// The front end takes no new edge until the current one has left the bit-serial remainder unit and been pushed.
// The back end counter update pops in B_IDLE and writes in B_UPDATE; a 2-entry queue decouples it from the front.
// A held result stalls the front end only once the queue is full.
// Reset (rst_n low, synchronous): part_count = 1, infer_interval = 1, all bucket
// counters read as zero, queue and output empty. No clearing pass is needed.
`timescale 1ns / 1ps

module hash_edge_bucket_router import heb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // edge input transaction
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NodeW-1:0]    in_source_node,
  input  logic [NodeW-1:0]    in_dest_node,
  input  logic                in_new_batch,
  // result transaction
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BucketW-1:0]  out_bucket,
  output logic [SlotW-1:0]    out_slot,
  output logic                out_infer_edge,
  output logic                out_slot_overflow,
  // register write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [PartW-1:0] part_count_r;
  logic [IvalW-1:0] infer_interval_r;
  heb_cfg_t         cfg;

  logic             q_push, q_ready, q_pop, q_valid;
  heb_task_t        q_in, q_out;

  // Register file. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r     <= PartW'(1);
      infer_interval_r <= IvalW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PART_COUNT:     part_count_r     <= cfg_wdata[PartW-1:0];
        REG_INFER_INTERVAL: infer_interval_r <= cfg_wdata[IvalW-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: zero part count acts as one, clamp to MAX_PARTS;
  // zero interval acts as one (every edge becomes an inference edge).
  always_comb begin
    cfg.parts = part_count_r;
    if (part_count_r == '0) begin
      cfg.parts = PartW'(1);
    end else if (int'(part_count_r) > MAX_PARTS) begin
      cfg.parts = PartW'(MAX_PARTS);
    end
    cfg.ival = (infer_interval_r == '0) ? IvalW'(1) : infer_interval_r;
  end

  // Front end: hash + classify, one edge in flight.
  heb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .in_new_batch   (in_new_batch),
    .cfg            (cfg),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_ready        (q_ready)
  );

  heb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  // Back end: counter read-modify-write, saturation, output register.
  heb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bucket        (out_bucket),
    .out_slot          (out_slot),
    .out_infer_edge    (out_infer_edge),
    .out_slot_overflow (out_slot_overflow)
  );

endmodule

// ===== rtl/core/heb_checker.sv =====
// Port-level checker for the edge bucket router, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heb_checker import heb_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BucketW-1:0]  out_bucket,
  input logic [SlotW-1:0]    out_slot,
  input logic                out_slot_overflow
);

  `HEB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_bucket), "stalled result changed or dropped")
  `HEB_ASSERT(a_single_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready, "front end took a second edge while busy")
  `HEB_ASSERT(a_ovf_slot, clk, rst_n, out_valid && out_slot_overflow |-> out_slot == SLOT_MAX, "overflow result without saturated slot")
  `HEB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind hash_edge_bucket_router heb_checker u_heb_checker (.*);

// ===== sim/tb_hash_edge_bucket_router.sv =====
// Self-checking testbench for hash_edge_bucket_router: directed and random edge streams.
`timescale 1ns / 1ps

// Scoreboard: mirrors register state and bucket counters, queues expected routes in order.
class edge_route_board;
  typedef struct {
    bit [heb_pkg::BucketW-1:0] bucket;
    bit [heb_pkg::SlotW-1:0]   slot;
    bit                        infer_edge;
    bit                        slot_overflow;
  } route_t;

  bit [heb_pkg::PartW-1:0]       part_reg;
  bit [heb_pkg::IvalW-1:0]       ival_reg;
  bit [heb_pkg::COUNT_WIDTH-1:0] bucket_slots[heb_pkg::NumBuckets];
  route_t                        pending_routes[$];
  int                            errors;

  function new();
    part_reg = 1;
    ival_reg = 1;
    foreach (bucket_slots[i]) bucket_slots[i] = '0;
    errors = 0;
  endfunction

  function void write_reg(bit [heb_pkg::CfgIdxW-1:0] idx, bit [heb_pkg::CfgDataW-1:0] data);
    if (idx == heb_pkg::REG_PART_COUNT)
      part_reg = data[heb_pkg::PartW-1:0];
    else if (idx == heb_pkg::REG_INFER_INTERVAL)
      ival_reg = data[heb_pkg::IvalW-1:0];
  endfunction

  // 64-bit murmur finalizer
  function bit [63:0] fmix(bit [63:0] v);
    v = v ^ (v >> heb_pkg::FMIX_SHIFT);
    v = v * 64'(heb_pkg::FMIX_MUL1);
    v = v ^ (v >> heb_pkg::FMIX_SHIFT);
    v = v * 64'(heb_pkg::FMIX_MUL2);
    v = v ^ (v >> heb_pkg::FMIX_SHIFT);
    return v;
  endfunction

  function void note_edge(bit [heb_pkg::NodeW-1:0] src, bit [heb_pkg::NodeW-1:0] dst,
                          bit new_batch);
    bit [63:0] parts;
    bit [63:0] ival;
    bit [63:0] hs;
    bit [63:0] hd;
    bit [63:0] b;
    bit        infer;
    route_t    r;
    parts = (part_reg == 0) ? 64'd1 :
            (part_reg > heb_pkg::MAX_PARTS) ? 64'(heb_pkg::MAX_PARTS) : 64'(part_reg);
    ival  = (ival_reg == 0) ? 64'd1 : 64'(ival_reg);
    hs    = fmix(64'(src));
    hd    = fmix(64'(dst));
    infer = ((hs % ival) == 0) || ((hd % ival) == 0);
    if (new_batch)
      foreach (bucket_slots[i]) bucket_slots[i] = '0;
    b = infer ? parts : (hd % parts);
    r.bucket     = b[heb_pkg::BucketW-1:0];
    r.infer_edge = infer;
    if (bucket_slots[b] == heb_pkg::COUNT_MAX) begin
      r.slot          = heb_pkg::SLOT_MAX;
      r.slot_overflow = 1'b1;
    end else begin
      r.slot          = heb_pkg::SlotW'(bucket_slots[b]);
      r.slot_overflow = 1'b0;
      bucket_slots[b] = bucket_slots[b] + 1'b1;
    end
    pending_routes.insert(pending_routes.size(), r);
  endfunction

  function void check_route(logic [heb_pkg::BucketW-1:0] bucket, logic [heb_pkg::SlotW-1:0] slot,
                            logic infer_edge, logic slot_overflow);
    route_t r;
    if (pending_routes.size() == 0) begin
      $error("unexpected result: bucket %0d slot %0d", bucket, slot);
      errors++;
      return;
    end
    r = pending_routes.pop_front();
    if (bucket !== r.bucket) begin
      $error("bucket: expected %0d, actual %0d", r.bucket, bucket);
      errors++;
    end
    if (slot !== r.slot) begin
      $error("slot: expected %0d, actual %0d", r.slot, slot);
      errors++;
    end
    if (infer_edge !== r.infer_edge) begin
      $error("infer_edge: expected %0d, actual %0d", r.infer_edge, infer_edge);
      errors++;
    end
    if (slot_overflow !== r.slot_overflow) begin
      $error("slot_overflow: expected %0d, actual %0d", r.slot_overflow, slot_overflow);
      errors++;
    end
  endfunction
endclass

module tb_hash_edge_bucket_router;
  import heb_pkg::*;

  localparam logic [NodeW-1:0]   MAX_ID = '1;
  // indexes the block has no register for; writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_UNUSED_A = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_UNUSED_B = CfgIdxW'(3);
  localparam int RANDOM_PHASES   = 8;
  localparam int EDGES_PER_PHASE = 200;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 100;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [NodeW-1:0]    in_source_node = '0;
  logic [NodeW-1:0]    in_dest_node = '0;
  logic                in_new_batch = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BucketW-1:0]  out_bucket;
  logic [SlotW-1:0]    out_slot;
  logic                out_infer_edge;
  logic                out_slot_overflow;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  edge_route_board board = new();

  // idling knobs, percent per edge (send) and per cycle (receive); changed between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_burst    = 0;
  int quiet_cycles   = 0;

  hash_edge_bucket_router u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_source_node    (in_source_node),
    .in_dest_node      (in_dest_node),
    .in_new_batch      (in_new_batch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bucket        (out_bucket),
    .out_slot          (out_slot),
    .out_infer_edge    (out_infer_edge),
    .out_slot_overflow (out_slot_overflow),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check each accepted transaction, then pick next cycle's ready.
  // Stall modes also throw in rare long bursts so the internal queue fills and
  // back-pressure reaches in_ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_route(out_bucket, out_slot, out_infer_edge, out_slot_overflow);
    if (stall_burst > 0) begin
      stall_burst--;
      out_ready <= 1'b0;
    end else if (recv_stall_pct > 0 && $urandom_range(299) == 0) begin
      stall_burst = $urandom_range(300, 50);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any stretch with no transaction on either channel this long is a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one edge and hold it until accepted. The optional gap before it is
  // long enough to land anywhere in the block's hash/remainder pass.
  // in_valid is left high on return so a back-to-back edge never drops it.
  task automatic send_edge(logic [NodeW-1:0] src, logic [NodeW-1:0] dst, logic nb);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(160, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_node <= src;
    in_dest_node   <= dst;
    in_new_batch   <= nb;
    do @(posedge clk); while (!in_ready);
    board.note_edge(src, dst, nb);
  endtask

  // Register write, only with the block drained: every edge yields exactly one
  // result, so an empty expectation queue means nothing is in flight.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    in_valid <= 1'b0;
    while (board.pending_routes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  // Node id mix: hash(0) is 0 so id 0 is always an inference target; small ids
  // repeat and stack up slots; the rest is full-width random.
  function automatic logic [NodeW-1:0] pick_node();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return MAX_ID;
      2, 3, 4: return NodeW'($urandom_range(31));
      default: return r[NodeW-1:0];
    endcase
  endfunction

  // Part count for a random phase; 0 and values above 64 hit the clamp cases.
  // Upper data bits are random since only the low 7 bits land in the register.
  function automatic logic [CfgDataW-1:0] phase_parts(int ph);
    logic [31:0]      r;
    logic [PartW-1:0] p;
    r = $urandom;
    case (ph)
      0:       p = 7'd1;
      1:       p = 7'd64;
      2:       p = 7'd0;
      3:       p = 7'd127;
      4:       p = 7'd2;
      6:       p = 7'd100;
      default: p = PartW'($urandom_range(64, 1));
    endcase
    return {r[CfgDataW-1:PartW], p};
  endfunction

  // Inference interval: 1 and 0 send everything to the extra bucket, small
  // moduli mix both kinds, the full-range values make inference rare.
  function automatic logic [CfgDataW-1:0] phase_ival(int ph);
    logic [31:0] r;
    r = $urandom;
    case (ph)
      0:       return CfgDataW'(1);
      1:       return '1;
      2:       return '0;
      3:       return CfgDataW'(2);
      4:       return CfgDataW'(3);
      5:       return CfgDataW'($urandom_range(16, 4));
      6:       return r[CfgDataW-1:0];
      default: return CfgDataW'(5);
    endcase
  endfunction

  initial begin
    logic [31:0] r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset config: one bucket, interval 1, so every edge is an inference edge
    send_edge('0, '0, 1'b0);
    send_edge(MAX_ID, MAX_ID, 1'b0);
    send_edge('0, MAX_ID, 1'b1);       // new batch restarts the slot count

    // widest part count, widest interval: mostly ordinary buckets
    write_reg(REG_PART_COUNT, CfgDataW'(64));
    write_reg(REG_INFER_INTERVAL, '1);
    send_edge(NodeW'(1), NodeW'(2), 1'b0);
    send_edge(MAX_ID, '0, 1'b0);       // dest 0 hashes to 0: inference edge
    send_edge(NodeW'(12345), NodeW'(678), 1'b0);
    send_edge(MAX_ID, MAX_ID - 1'b1, 1'b0);
    send_edge(NodeW'(5), NodeW'(5), 1'b1);

    // part count 127 clamps to 64; zero interval acts as 1
    write_reg(REG_PART_COUNT, '1);
    write_reg(REG_INFER_INTERVAL, '0);
    send_edge(NodeW'(3), NodeW'(4), 1'b0);
    send_edge(NodeW'(3), NodeW'(4), 1'b0);

    // zero part count acts as 1 (upper data bits set but masked off)
    write_reg(REG_PART_COUNT, {{(CfgDataW-PartW){1'b1}}, {PartW{1'b0}}});
    write_reg(REG_INFER_INTERVAL, CfgDataW'(2));
    repeat (3) send_edge(pick_node(), pick_node(), 1'b0);

    // writes to unmapped indexes change nothing
    r = $urandom;
    write_reg(REG_UNUSED_A, r[CfgDataW-1:0]);
    r = $urandom;
    write_reg(REG_UNUSED_B, r[CfgDataW-1:0]);
    send_edge(NodeW'(9), NodeW'(10), 1'b0);
    send_edge(NodeW'(11), NodeW'(12), 1'b0);

    write_reg(REG_PART_COUNT, CfgDataW'(7));
    write_reg(REG_INFER_INTERVAL, CfgDataW'(3));
    send_edge(NodeW'(20), NodeW'(21), 1'b0);
    send_edge(NodeW'(20), NodeW'(21), 1'b0);
    send_edge(NodeW'(20), NodeW'(21), 1'b1);
    send_edge(NodeW'(20), NodeW'(21), 1'b0);

    // ---- random part: one register setting per phase, idling mode rotates ----
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_reg(REG_PART_COUNT, phase_parts(ph));
      write_reg(REG_INFER_INTERVAL, phase_ival(ph));
      repeat (EDGES_PER_PHASE)
        send_edge(pick_node(), pick_node(), $urandom_range(99) < 3);
    end

    // ---- drain ----
    in_valid <= 1'b0;
    while (board.pending_routes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_routes.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
